@@ design/fvdi_pkg.sv @@
`default_nettype none

package fvdi_pkg;

  // Field widths of the corner and result transactions.
  localparam int SLOT_W   = 17;
  localparam int COUNT_W  = 16;
  localparam int VID_W    = 12;
  localparam int NV_W     = 13;
  localparam int KEY_W    = 3 * SLOT_W;
  localparam int CFG_IDX_W = 2;

  // Vertex ids stop at this count whatever the table size.
  localparam int VID_LIMIT = 4096;

  // References beyond this magnitude are saturated before resolving.
  localparam int REF_LIMIT = 65535;

  localparam int TABLE_ENTRIES_DEFAULT = 4096;
  localparam int QUEUE_DEPTH = 2;

  // Hash of the resolved triple: three products, XOR-ed, then folded.
  localparam int HASH_W = SLOT_W + 32;
  localparam int HASH_FOLD = 29;
  localparam logic [31:0] HASH_MUL_P = 32'h9E37_79B1;
  localparam logic [31:0] HASH_MUL_T = 32'h85EB_CA77;
  localparam logic [31:0] HASH_MUL_N = 32'hC2B2_AE3D;

  // Table entries carry an epoch tag; tag zero marks an empty entry.
  localparam int EPOCH_W = 4;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POSITION_COUNT = 2'd0,
    REG_TEXCOORD_COUNT = 2'd1,
    REG_NORMAL_COUNT   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_FOLD,
    F_MOD
  } front_state_t;

  typedef enum logic [2:0] {
    B_SWEEP,
    B_IDLE,
    B_PROBE,
    B_CHECK,
    B_EMIT
  } back_state_t;

  typedef struct packed {
    logic [COUNT_W-1:0] position_count;
    logic [COUNT_W-1:0] texcoord_count;
    logic [COUNT_W-1:0] normal_count;
  } counts_t;

  // One classified corner as it travels from the front to the back.
  typedef struct packed {
    logic              mesh_start;
    logic [SLOT_W-1:0] pos_slot;
    logic [SLOT_W-1:0] tex_slot;
    logic [SLOT_W-1:0] norm_slot;
  } corner_t;

  localparam int CORNER_W = $bits(corner_t);

  // Turns an OBJ reference into a zero-based slot; all-ones means absent.
  function automatic logic [SLOT_W-1:0] resolve_ref(input logic [SLOT_W-1:0] ref_bits,
                                                    input logic [COUNT_W-1:0] count);
    logic signed [31:0] r;
    logic signed [31:0] res;
    r = 32'(signed'(ref_bits));
    if (r > REF_LIMIT) begin
      r = REF_LIMIT;
    end
    if (r < -(REF_LIMIT + 1)) begin
      r = -(REF_LIMIT + 1);
    end
    if (r > 0) begin
      res = r - 32'sd1;
    end else if (r < 0) begin
      res = $signed({{(32 - COUNT_W){1'b0}}, count}) + r;
    end else begin
      res = -32'sd1;
    end
    return res[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ design/fvdi_queue.sv @@
`default_nettype none

module fvdi_queue import fvdi_pkg::*; #(
  parameter int WIDTH = CORNER_W,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign full     = (fill == CW'(DEPTH));
  assign empty    = (fill == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ design/fvdi_front.sv @@
`default_nettype none

module fvdi_front import fvdi_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [SLOT_W-1:0]          pos_ref,
  input  wire logic signed [SLOT_W-1:0]          tex_ref,
  input  wire logic signed [SLOT_W-1:0]          norm_ref,
  input  wire logic                              mesh_start,
  input  wire counts_t                           counts,
  output logic                                   q_push,
  output corner_t                                q_item,
  output logic [$clog2(TABLE_ENTRIES)-1:0]       q_home,
  input  wire logic                              q_full
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam bit POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

  front_state_t      state;
  front_state_t      state_next;
  corner_t           corner;
  logic [HASH_W-1:0] prod_p;
  logic [HASH_W-1:0] prod_t;
  logic [HASH_W-1:0] prod_n;
  logic [HASH_W-1:0] prod_x;
  logic [HASH_W-1:0] fold;
  logic [AW-1:0]     home;
  logic              home_done;

  assign q_item = corner;
  assign q_home = home;

  // The three products are XOR-ed and folded onto themselves.
  assign prod_x = prod_p ^ prod_t ^ prod_n;
  assign fold   = prod_x ^ (prod_x >> HASH_FOLD);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake.
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    q_push     = 1'b0;
    unique case (state)
      F_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = F_MUL;
        end
      end
      F_MUL: begin
        state_next = F_FOLD;
      end
      F_FOLD: begin
        state_next = F_MOD;
      end
      F_MOD: begin
        if (home_done && !q_full) begin
          q_push     = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

  // Resolve the references as the transaction is taken.
  always_ff @(posedge clk) begin
    if (state == F_IDLE && in_valid) begin
      corner.mesh_start <= mesh_start;
      corner.pos_slot   <= resolve_ref(pos_ref, counts.position_count);
      corner.tex_slot   <= resolve_ref(tex_ref, counts.texcoord_count);
      corner.norm_slot  <= resolve_ref(norm_ref, counts.normal_count);
    end
  end

  // Hash products, one register stage.
  always_ff @(posedge clk) begin
    if (state == F_MUL) begin
      prod_p <= HASH_W'(corner.pos_slot) * HASH_W'(HASH_MUL_P);
      prod_t <= HASH_W'(corner.tex_slot) * HASH_W'(HASH_MUL_T);
      prod_n <= HASH_W'(corner.norm_slot) * HASH_W'(HASH_MUL_N);
    end
  end

  generate
    if (POW2) begin : g_mask
      // A power-of-two table takes the low bits of the folded hash.
      logic [AW-1:0] home_bits;

      always_ff @(posedge clk) begin
        if (state == F_FOLD) begin
          home_bits <= fold[AW-1:0];
        end
      end

      assign home      = home_bits;
      assign home_done = 1'b1;
    end else begin : g_serial
      // Any other size reduces the hash one bit per cycle, most significant first.
      localparam int CW = $clog2(HASH_W + 1);
      localparam logic [AW:0] MODULUS = (AW + 1)'(TABLE_ENTRIES);

      logic [HASH_W-1:0] hash_shift;
      logic [AW-1:0]     rem;
      logic [AW:0]       rem_shift;
      logic [AW:0]       rem_red;
      logic [CW-1:0]     bits_left;

      assign rem_shift = {rem, hash_shift[HASH_W-1]};
      assign rem_red   = (rem_shift >= MODULUS) ? rem_shift - MODULUS : rem_shift;

      always_ff @(posedge clk) begin
        if (state == F_FOLD) begin
          hash_shift <= fold;
          rem        <= '0;
          bits_left  <= CW'(HASH_W);
        end else if (state == F_MOD && bits_left != '0) begin
          hash_shift <= hash_shift << 1;
          rem        <= rem_red[AW-1:0];
          bits_left  <= bits_left - 1'b1;
        end
      end

      assign home      = rem;
      assign home_done = (bits_left == '0);
    end
  endgenerate

endmodule

`default_nettype wire

@@ design/fvdi_back.sv @@
`default_nettype none

module fvdi_back import fvdi_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_empty,
  input  wire corner_t                       q_item,
  input  wire logic [$clog2(TABLE_ENTRIES)-1:0] q_home,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [VID_W-1:0]                   vertex_id,
  output logic [1:0]                         status,
  output logic signed [SLOT_W-1:0]           pos_slot,
  output logic signed [SLOT_W-1:0]           tex_slot,
  output logic signed [SLOT_W-1:0]           norm_slot
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int MW = EPOCH_W + KEY_W + VID_W;
  localparam int VID_CAP = (TABLE_ENTRIES < VID_LIMIT) ? TABLE_ENTRIES : VID_LIMIT;
  localparam logic [AW-1:0]   LAST_ADDR = AW'(TABLE_ENTRIES - 1);
  localparam logic [NV_W-1:0] NV_CAP = NV_W'(VID_CAP);

  // Entry word: epoch tag, key, vertex id.
  logic [MW-1:0] entry_mem [TABLE_ENTRIES];
  logic [MW-1:0] rd_word;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [MW-1:0] wr_word;
  logic          wr_en;

  back_state_t        state;
  back_state_t        state_next;
  logic [EPOCH_W-1:0] epoch;
  logic [EPOCH_W-1:0] epoch_next;
  logic [NV_W-1:0]    next_vertex;
  logic [NV_W-1:0]    next_vertex_next;
  logic [AW-1:0]      sweep_addr;
  logic [AW-1:0]      sweep_addr_next;
  logic [AW-1:0]      probe_addr;
  logic [AW-1:0]      probe_addr_next;
  logic [AW-1:0]      probe_addr_inc;
  logic [AW-1:0]      probe_cnt;
  logic [AW-1:0]      probe_cnt_next;
  logic               resume;
  logic               resume_next;
  corner_t            item;
  corner_t            item_next;
  logic [VID_W-1:0]   res_vid;
  logic [VID_W-1:0]   res_vid_next;
  status_t            res_status;
  status_t            res_status_next;
  logic               out_load;

  logic [EPOCH_W-1:0] entry_tag;
  logic [KEY_W-1:0]   entry_key;
  logic [VID_W-1:0]   entry_vid;
  logic [KEY_W-1:0]   item_key;

  assign entry_tag      = rd_word[MW-1 -: EPOCH_W];
  assign entry_key      = rd_word[VID_W +: KEY_W];
  assign entry_vid      = rd_word[VID_W-1:0];
  assign item_key       = {item.pos_slot, item.tex_slot, item.norm_slot};
  assign probe_addr_inc = (probe_addr == LAST_ADDR) ? '0 : probe_addr + 1'b1;

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_word;
    end
    rd_word <= entry_mem[rd_addr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_SWEEP;
      epoch       <= '0;
      next_vertex <= '0;
      sweep_addr  <= '0;
      resume      <= 1'b0;
    end else begin
      state       <= state_next;
      epoch       <= epoch_next;
      next_vertex <= next_vertex_next;
      sweep_addr  <= sweep_addr_next;
      resume      <= resume_next;
    end
  end

  // Probe position and the corner being looked up.
  always_ff @(posedge clk) begin
    probe_addr <= probe_addr_next;
    probe_cnt  <= probe_cnt_next;
    item       <= item_next;
    res_vid    <= res_vid_next;
    res_status <= res_status_next;
  end

  // Sweep, lookup and insert sequencing.
  always_comb begin
    state_next       = state;
    epoch_next       = epoch;
    next_vertex_next = next_vertex;
    sweep_addr_next  = sweep_addr;
    resume_next      = resume;
    probe_addr_next  = probe_addr;
    probe_cnt_next   = probe_cnt;
    item_next        = item;
    res_vid_next     = res_vid;
    res_status_next  = res_status;
    rd_addr          = probe_addr;
    wr_en            = 1'b0;
    wr_addr          = probe_addr;
    wr_word          = {epoch, item_key, next_vertex[VID_W-1:0]};
    q_pop            = 1'b0;
    out_load         = 1'b0;

    unique case (state)
      B_SWEEP: begin
        // Mark every entry empty, then start the first epoch.
        wr_en           = 1'b1;
        wr_addr         = sweep_addr;
        wr_word         = '0;
        sweep_addr_next = sweep_addr + 1'b1;
        if (sweep_addr == LAST_ADDR) begin
          sweep_addr_next = '0;
          epoch_next      = EPOCH_FIRST;
          resume_next     = 1'b0;
          state_next      = resume ? B_PROBE : B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop           = 1'b1;
          item_next       = q_item;
          probe_addr_next = q_home;
          probe_cnt_next  = '0;
          state_next      = B_PROBE;
          if (q_item.mesh_start) begin
            next_vertex_next = '0;
            if (epoch == EPOCH_MAX) begin
              resume_next = 1'b1;
              state_next  = B_SWEEP;
            end else begin
              epoch_next = epoch + 1'b1;
            end
          end
        end
      end
      B_PROBE: begin
        state_next = B_CHECK;
      end
      B_CHECK: begin
        if (entry_tag != epoch) begin
          // Empty entry ends the probe: insert if ids remain.
          state_next = B_EMIT;
          if (next_vertex < NV_CAP) begin
            wr_en            = 1'b1;
            res_vid_next     = next_vertex[VID_W-1:0];
            res_status_next  = ST_INSERTED;
            next_vertex_next = next_vertex + 1'b1;
          end else begin
            res_vid_next    = '0;
            res_status_next = ST_FULL;
          end
        end else if (entry_key == item_key) begin
          res_vid_next    = entry_vid;
          res_status_next = ST_FOUND;
          state_next      = B_EMIT;
        end else if (probe_cnt == LAST_ADDR) begin
          // Every entry has been visited without a match or a hole.
          res_vid_next    = '0;
          res_status_next = ST_FULL;
          state_next      = B_EMIT;
        end else begin
          probe_addr_next = probe_addr_inc;
          probe_cnt_next  = probe_cnt + 1'b1;
          rd_addr         = probe_addr_inc;
        end
      end
      B_EMIT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      vertex_id <= res_vid;
      status    <= res_status;
      pos_slot  <= $signed(item.pos_slot);
      tex_slot  <= $signed(item.tex_slot);
      norm_slot <= $signed(item.norm_slot);
    end
  end

endmodule

`default_nettype wire

@@ design/face_vertex_dedup_indexer_top.sv @@
// Vertex deduplication indexer for OBJ face corners.
// Input channel (in_valid/in_stall): one corner per transaction, three OBJ
// references and a mesh_start flag that empties the table before the corner.
// Output channel (out_valid/out_stall): one result per corner, in order: the
// vertex id, a found/inserted/full status and the three resolved slots.
// Configuration channel (cfg_valid/cfg_ready, always ready): index 0, 1, 2
// write the position, texcoord and normal counts; other indexes are dropped.
// The front resolves the references as it takes a corner, then registers the
// hash products, folds them and reduces the hash to a home index (bit-serially
// when TABLE_ENTRIES is not a power of two), and hands it through a two-entry
// queue to the back. The back pops a corner, reads its home entry and checks
// it; each further table probe waits on another registered read of the table
// memory. After reset the back sweeps every table entry empty before the
// first lookup; the same sweep follows every 15th mesh_start. The front takes
// a new corner only after it has pushed the last one into the queue, and
// stalls while the queue is full. A stalled result holds in the output
// register while the next corner is looked up behind it.
`default_nettype none

module face_vertex_dedup_indexer_top import fvdi_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [SLOT_W-1:0] pos_ref,
  input  wire logic signed [SLOT_W-1:0] tex_ref,
  input  wire logic signed [SLOT_W-1:0] norm_ref,
  input  wire logic                     mesh_start,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [VID_W-1:0]              vertex_id,
  output logic [1:0]                    status,
  output logic signed [SLOT_W-1:0]      pos_slot,
  output logic signed [SLOT_W-1:0]      tex_slot,
  output logic signed [SLOT_W-1:0]      norm_slot,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [COUNT_W-1:0]       cfg_data
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int QW = AW + CORNER_W;

  counts_t        counts;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  corner_t        front_item;
  logic [AW-1:0]  front_home;
  logic [QW-1:0]  push_data;
  logic [QW-1:0]  pop_data;
  corner_t        back_item;
  logic [AW-1:0]  back_home;

  assign cfg_ready = 1'b1;

  // Attribute count registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      counts <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POSITION_COUNT: counts.position_count <= cfg_data;
        REG_TEXCOORD_COUNT: counts.texcoord_count <= cfg_data;
        REG_NORMAL_COUNT:   counts.normal_count   <= cfg_data;
        default: ;
      endcase
    end
  end

  fvdi_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pos_ref    (pos_ref),
    .tex_ref    (tex_ref),
    .norm_ref   (norm_ref),
    .mesh_start (mesh_start),
    .counts     (counts),
    .q_push     (q_push),
    .q_item     (front_item),
    .q_home     (front_home),
    .q_full     (q_full)
  );

  // Queue transactions carry the home index above the corner.
  assign push_data = {front_home, front_item};
  assign back_home = pop_data[CORNER_W +: AW];
  assign back_item = corner_t'(pop_data[CORNER_W-1:0]);

  fvdi_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  fvdi_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_item    (back_item),
    .q_home    (back_home),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .vertex_id (vertex_id),
    .status    (status),
    .pos_slot  (pos_slot),
    .tex_slot  (tex_slot),
    .norm_slot (norm_slot)
  );

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
module testbench;
  import fvdi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SIZE = 4096;
  localparam int VID_CAP = 4096;
  localparam int RUN_LIMIT = 4_000_000;

  // Register index that the block drops.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // Hash multipliers and fold distance of the key table.
  localparam logic [31:0] MIX_P = 32'h9E37_79B1;
  localparam logic [31:0] MIX_T = 32'h85EB_CA77;
  localparam logic [31:0] MIX_N = 32'hC2B2_AE3D;
  localparam int MIX_SHIFT = 29;

  // Largest positive and most negative reference, and the absent slot.
  localparam logic [SLOT_W-1:0] REF_TOP = 17'h0FFFF;
  localparam logic [SLOT_W-1:0] REF_BOTTOM = 17'h10000;
  localparam logic [SLOT_W-1:0] REF_LAST = 17'h1FFFF;

  typedef struct packed {
    logic [SLOT_W-1:0] pos_ref;
    logic [SLOT_W-1:0] tex_ref;
    logic [SLOT_W-1:0] norm_ref;
    logic              mesh_start;
  } face_corner_s;

  typedef struct packed {
    logic [VID_W-1:0]  vid;
    status_t           st;
    logic [SLOT_W-1:0] ps;
    logic [SLOT_W-1:0] ts;
    logic [SLOT_W-1:0] ns;
  } vertex_result_s;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SLOT_W-1:0] pos_ref = '0;
  logic signed [SLOT_W-1:0] tex_ref = '0;
  logic signed [SLOT_W-1:0] norm_ref = '0;
  logic mesh_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [VID_W-1:0] vertex_id;
  logic [1:0] status;
  logic signed [SLOT_W-1:0] pos_slot;
  logic signed [SLOT_W-1:0] tex_slot;
  logic signed [SLOT_W-1:0] norm_slot;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COUNT_W-1:0] cfg_data = '0;

  face_vertex_dedup_indexer_top u_dut (.*);

  initial forever #4 clk = ~clk;

  // Shadow of the attribute counts and of the key table.
  logic [COUNT_W-1:0] cnt_pos = '0;
  logic [COUNT_W-1:0] cnt_tex = '0;
  logic [COUNT_W-1:0] cnt_norm = '0;
  bit tbl_used [TABLE_SIZE];
  logic [KEY_W-1:0] tbl_key [TABLE_SIZE];
  logic [VID_W-1:0] tbl_vid [TABLE_SIZE];
  int next_vid = 0;

  face_corner_s pending_corners[$];
  vertex_result_s expected_vertices[$];
  vertex_result_s exp_res;
  int mismatches = 0;
  int results_seen = 0;
  int gap_left = 0;
  int burst_left = 0;
  int hold_left = 0;
  int next_hold_at = 300;
  int stall_pct = 0;
  int pattern_left = 0;
  int cycle_count = 0;

  // Positive references are one-based, negative ones count back from the count.
  function automatic logic [SLOT_W-1:0] resolve_slot(logic [SLOT_W-1:0] ref_bits,
                                                     logic [COUNT_W-1:0] count);
    int v;
    v = $signed(ref_bits);
    if (v > 0) begin
      return SLOT_W'(v - 1);
    end else if (v < 0) begin
      return SLOT_W'(int'(count) + v);
    end
    return REF_LAST;
  endfunction

  // Looks the resolved triple up with linear probing and inserts it when new.
  function automatic vertex_result_s predict_vertex(face_corner_s c);
    vertex_result_s r;
    logic [KEY_W-1:0] key;
    logic [63:0] h;
    int home;
    int idx;
    int free_idx;
    bit got_free;
    if (c.mesh_start) begin
      foreach (tbl_used[j]) tbl_used[j] = 1'b0;
      next_vid = 0;
    end
    r.ps = resolve_slot(c.pos_ref, cnt_pos);
    r.ts = resolve_slot(c.tex_ref, cnt_tex);
    r.ns = resolve_slot(c.norm_ref, cnt_norm);
    key = {r.ps, r.ts, r.ns};
    h = (64'(r.ps) * 64'(MIX_P)) ^ (64'(r.ts) * 64'(MIX_T)) ^ (64'(r.ns) * 64'(MIX_N));
    h = h ^ (h >> MIX_SHIFT);
    home = int'(h % TABLE_SIZE);
    r.vid = '0;
    r.st = ST_FULL;
    got_free = 1'b0;
    free_idx = 0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      idx = (home + i) % TABLE_SIZE;
      if (!tbl_used[idx]) begin
        got_free = 1'b1;
        free_idx = idx;
        break;
      end
      if (tbl_key[idx] == key) begin
        r.vid = tbl_vid[idx];
        r.st = ST_FOUND;
        break;
      end
    end
    if (r.st == ST_FULL && got_free && next_vid < TABLE_SIZE && next_vid < VID_CAP) begin
      tbl_used[free_idx] = 1'b1;
      tbl_key[free_idx] = key;
      tbl_vid[free_idx] = VID_W'(next_vid);
      r.vid = VID_W'(next_vid);
      r.st = ST_INSERTED;
      next_vid++;
    end
    return r;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s", msg);
    end
  endfunction

  // Mostly references from a small pool so corners repeat, plus extremes and noise.
  function automatic logic [SLOT_W-1:0] pick_ref(int pool);
    int v;
    v = $urandom_range(1, pool);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return SLOT_W'(v);
      5, 6: return SLOT_W'(-v);
      7: return '0;
      8: begin
        case ($urandom_range(0, 3))
          0: return REF_TOP;
          1: return REF_BOTTOM;
          2: return SLOT_W'(1);
          default: return REF_LAST;
        endcase
      end
      default: return SLOT_W'($urandom());
    endcase
  endfunction

  // Driver: offers queued corners in bursts and predicts each accepted transaction.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_vertices.push_back(predict_vertex(pending_corners[0]));
        void'(pending_corners.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_corners.size() != 0) begin
          in_valid <= 1'b1;
          pos_ref <= pending_corners[0].pos_ref;
          tex_ref <= pending_corners[0].tex_ref;
          norm_ref <= pending_corners[0].norm_ref;
          mesh_start <= pending_corners[0].mesh_start;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall pattern, with a long hold-off every so many results.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (results_seen >= next_hold_at) begin
      hold_left = 400;
      next_hold_at = next_hold_at + 900;
      out_stall <= 1'b1;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      pattern_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Monitor: each result transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (expected_vertices.size() == 0) begin
        note_mismatch($sformatf("unexpected result: vid %0d status %0d slots %h %h %h",
                                vertex_id, status, pos_slot, tex_slot, norm_slot));
      end else begin
        exp_res = expected_vertices.pop_front();
        if (vertex_id !== exp_res.vid || status !== exp_res.st || pos_slot !== exp_res.ps ||
            tex_slot !== exp_res.ts || norm_slot !== exp_res.ns) begin
          note_mismatch($sformatf(
            "mismatch: got vid %0d status %0d slots %h %h %h, exp vid %0d status %0d slots %h %h %h",
            vertex_id, status, pos_slot, tex_slot, norm_slot,
            exp_res.vid, exp_res.st, exp_res.ps, exp_res.ts, exp_res.ns));
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL face_vertex_dedup_indexer_top");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_POSITION_COUNT: cnt_pos = val;
      REG_TEXCOORD_COUNT: cnt_tex = val;
      REG_NORMAL_COUNT: cnt_norm = val;
      default: ;
    endcase
  endtask

  task automatic set_counts(input logic [COUNT_W-1:0] p, input logic [COUNT_W-1:0] t,
                            input logic [COUNT_W-1:0] n);
    write_reg(REG_POSITION_COUNT, p);
    write_reg(REG_TEXCOORD_COUNT, t);
    write_reg(REG_NORMAL_COUNT, n);
  endtask

  // Waits until every corner is accepted and every result has come back.
  task automatic drain();
    while (pending_corners.size() != 0) @(posedge clk);
    while (expected_vertices.size() != 0) @(posedge clk);
  endtask

  task automatic push_corner(input logic [SLOT_W-1:0] p, input logic [SLOT_W-1:0] t,
                             input logic [SLOT_W-1:0] n, input logic ms);
    face_corner_s c;
    c.pos_ref = p;
    c.tex_ref = t;
    c.norm_ref = n;
    c.mesh_start = ms;
    pending_corners.push_back(c);
  endtask

  // Meshes of corners drawn from small pools, with some raw noise mixed in.
  task automatic run_meshes(input int n_items);
    int left;
    int mesh_len;
    int pp;
    int tp;
    int np;
    left = n_items;
    while (left > 0) begin
      mesh_len = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 400) : $urandom_range(4, 80);
      pp = $urandom_range(1, 32);
      tp = $urandom_range(1, 32);
      np = $urandom_range(1, 32);
      for (int k = 0; k < mesh_len && left > 0; k++) begin
        if ($urandom_range(0, 11) == 0) begin
          push_corner(SLOT_W'($urandom()), SLOT_W'($urandom()), SLOT_W'($urandom()),
                      $urandom_range(0, 7) == 0);
        end else begin
          push_corner(pick_ref(pp), pick_ref(tp), pick_ref(np), k == 0);
        end
        left--;
      end
    end
    drain();
  endtask

  // Fills one mesh to capacity, probes the full table with misses and hits, then starts a new mesh.
  task automatic run_fill();
    face_corner_s first_c;
    face_corner_s mid_c;
    face_corner_s c;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      c.pos_ref = SLOT_W'(k + 1);
      c.tex_ref = pick_ref(8);
      c.norm_ref = pick_ref(8);
      c.mesh_start = (k == 0);
      if (k == 0) first_c = c;
      if (k == 2000) mid_c = c;
      pending_corners.push_back(c);
    end
    push_corner(SLOT_W'(40000), '0, '0, 1'b0);
    push_corner(first_c.pos_ref, first_c.tex_ref, first_c.norm_ref, 1'b0);
    push_corner(REF_BOTTOM, REF_TOP, REF_LAST, 1'b0);
    pending_corners.push_back(mid_c);
    push_corner(SLOT_W'(40000), '0, '0, 1'b1);
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Counts at their reset value: a negative reference lands below zero.
    push_corner(REF_LAST, REF_LAST, REF_LAST, 1'b1);
    push_corner('0, '0, '0, 1'b0);
    push_corner(REF_BOTTOM, '0, SLOT_W'(1), 1'b0);
    push_corner(REF_TOP, REF_TOP, REF_TOP, 1'b0);
    drain();

    // Counts at their maximum, plus a write to the unused index.
    set_counts('1, '1, '1);
    write_reg(REG_SPARE, 16'hA5C3);
    push_corner(REF_TOP, REF_BOTTOM, REF_LAST, 1'b1);
    push_corner(SLOT_W'(1), SLOT_W'(1), SLOT_W'(1), 1'b0);
    push_corner('0, '0, '0, 1'b0);
    push_corner(SLOT_W'(-65535), SLOT_W'(-65535), SLOT_W'(-65535), 1'b0);
    push_corner(REF_TOP, REF_BOTTOM, REF_LAST, 1'b0);
    push_corner(SLOT_W'(1), SLOT_W'(1), SLOT_W'(1), 1'b1);
    push_corner(SLOT_W'(2), '0, SLOT_W'(-2), 1'b0);
    push_corner(SLOT_W'(2), '0, SLOT_W'(-2), 1'b0);
    drain();

    // Random meshes under several count settings, extremes included.
    run_meshes(310);
    set_counts('0, '0, '0);
    write_reg(REG_SPARE, 16'($urandom()));
    run_meshes(310);
    set_counts(16'($urandom()), 16'($urandom()), 16'($urandom()));
    run_meshes(310);
    set_counts(16'd1, '1, '0);
    run_meshes(310);
    set_counts(16'($urandom()), 16'($urandom()), 16'($urandom()));
    write_reg(REG_SPARE, 16'($urandom()));
    run_meshes(310);
    set_counts(16'($urandom_range(1, 64)), 16'($urandom_range(1, 64)),
               16'($urandom_range(1, 64)));
    run_meshes(310);

    // Table exhaustion.
    set_counts(16'($urandom()), 16'($urandom()), 16'($urandom()));
    run_fill();

    repeat (32) @(posedge clk);
    if (mismatches == 0 && expected_vertices.size() == 0) begin
      $display("PASS face_vertex_dedup_indexer_top");
    end else begin
      $display("FAIL face_vertex_dedup_indexer_top");
    end
    $finish;
  end

endmodule

@@ face_vertex_dedup_indexer_top.f @@
design/fvdi_pkg.sv
design/fvdi_queue.sv
design/fvdi_front.sv
design/fvdi_back.sv
design/face_vertex_dedup_indexer_top.sv
tb/sv/testbench.sv
